FILE: design/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

  localparam int unsigned MAX_PIXEL_BYTES = 4;

  localparam logic [2:0] BPP_RESET   = 3'd3;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  // Configuration register indexes
  localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
  localparam logic CFG_PIXEL_TOTAL     = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_NORMAL    = 2'd0;
  localparam logic [1:0] ST_CLIPPED   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // Decoder phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_REPEAT  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [1:0]  status;
    logic        image_done;
  } result_t;

endpackage

FILE: design/tgarle_step.sv
// Per-byte packet decode: phase, pixel assembly and image pixel count.
module tgarle_step
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  input  logic [2:0]  bpp_eff,
  input  logic [31:0] total_eff,
  output logic        res_valid,
  output result_t     res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic [31:0] pixel_shift_r, pixel_shift_nxt;
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic [31:0] pixels_done_r, pixels_done_nxt;

  logic [2:0]  bi_inc;
  logic        pixel_complete;
  logic [31:0] shift_or;
  logic [32:0] diff;
  logic [31:0] remaining;
  logic [7:0]  want;
  logic        img_done;
  logic        clip_lt;
  logic [7:0]  give;
  logic [31:0] pd_sum;
  logic [7:0]  pl_dec;
  logic [7:0]  pl_after;

  assign bi_inc         = {1'b0, byte_index_r} + 3'd1;
  assign pixel_complete = bi_inc >= bpp_eff;
  assign shift_or       = pixel_shift_r | (32'(data_byte) << {byte_index_r, 3'b000});
  assign diff           = {1'b0, total_eff} - {1'b0, pixels_done_r};
  assign remaining      = diff[32] ? 32'd0 : diff[31:0];
  assign want           = (phase_r == PH_REPEAT) ? packet_left_r : 8'd1;
  // Image completes when the request covers every missing pixel.
  assign img_done       = (remaining[31:8] == 24'd0) && (want >= remaining[7:0]);
  assign clip_lt        = (remaining[31:8] == 24'd0) && (remaining[7:0] < want);
  assign give           = clip_lt ? remaining[7:0] : want;
  assign pd_sum         = pixels_done_r + 32'(want);
  assign pl_dec         = (packet_left_r != 8'd0) ? packet_left_r - 8'd1 : 8'd0;
  assign pl_after       = (phase_r == PH_REPEAT) ? 8'd0 : pl_dec;

  always_comb begin
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    pixel_shift_nxt = pixel_shift_r;
    packet_left_nxt = packet_left_r;
    pixels_done_nxt = pixels_done_r;
    res_valid       = 1'b0;
    res             = '0;
    if (stream_end) begin
      phase_nxt       = PH_HEADER;
      byte_index_nxt  = 2'd0;
      pixel_shift_nxt = 32'd0;
      packet_left_nxt = 8'd0;
      pixels_done_nxt = 32'd0;
      res_valid       = !((phase_r == PH_DISCARD) ||
                          ((phase_r == PH_HEADER) && (pixels_done_r == 32'd0)));
      res.status      = ST_TRUNCATED;
      res.image_done  = 1'b1;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          packet_left_nxt = {1'b0, data_byte[6:0]} + 8'd1;
          phase_nxt       = data_byte[7] ? PH_REPEAT : PH_LITERAL;
          byte_index_nxt  = 2'd0;
          pixel_shift_nxt = 32'd0;
        end
        PH_DISCARD: begin
          // Drop leftover literal bytes one pixel at a time
          if (pixel_complete) begin
            byte_index_nxt  = 2'd0;
            packet_left_nxt = pl_dec;
            if (pl_dec == 8'd0) phase_nxt = PH_HEADER;
          end else begin
            byte_index_nxt = bi_inc[1:0];
          end
        end
        default: begin
          if (!pixel_complete) begin
            pixel_shift_nxt = shift_or;
            byte_index_nxt  = bi_inc[1:0];
          end else begin
            pixel_shift_nxt  = 32'd0;
            byte_index_nxt   = 2'd0;
            res_valid        = 1'b1;
            res.pixel_value  = shift_or;
            res.repeat_count = give;
            res.status       = clip_lt ? ST_CLIPPED : ST_NORMAL;
            if (img_done) begin
              res.image_done  = 1'b1;
              pixels_done_nxt = 32'd0;
              if ((phase_r == PH_LITERAL) && (pl_after != 8'd0)) begin
                res.status      = ST_CLIPPED;
                phase_nxt       = PH_DISCARD;
                packet_left_nxt = pl_after;
              end else begin
                phase_nxt       = PH_HEADER;
                packet_left_nxt = 8'd0;
              end
            end else begin
              pixels_done_nxt = pd_sum;
              packet_left_nxt = pl_after;
              if (pl_after == 8'd0) phase_nxt = PH_HEADER;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      byte_index_r  <= 2'd0;
      pixel_shift_r <= 32'd0;
      packet_left_r <= 8'd0;
      pixels_done_r <= 32'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      pixel_shift_r <= pixel_shift_nxt;
      packet_left_r <= packet_left_nxt;
      pixels_done_r <= pixels_done_nxt;
    end
  end

  a_trunc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_TRUNCATED) |-> (res.repeat_count == 8'd0 && res.image_done))
    else $error("truncation result with nonzero count or no image_done");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.repeat_count <= 8'd128))
    else $error("repeat count above 128");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.image_done) |=> (pixels_done_r == 32'd0))
    else $error("pixel count not cleared after image end");

endmodule

FILE: design/tgarle_skid.sv
// Two-entry result buffer: output register plus skid register.
module tgarle_skid
  import tgarle_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Payload moves only on a request taken or an empty slot filled
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (!main_valid_r || pop) main_r <= push_data;
      else skid_r <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed into full buffer");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output register");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

FILE: design/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Usage:
//   Input channel (in_valid/in_stall): one compressed stream byte per request
//   on in_data_byte, or in_stream_end high to mark the end of the source.
//   Output channel (out_valid/out_stall): one decoded run per request: pixel
//   value (first stream byte in bits 7:0), repeat count, status and image_done.
//   Runs are not expanded; an unclipped literal pixel has repeat count 1.
//   Configuration (cfg_valid/cfg_ready, always ready): index 0 sets bytes per
//   pixel, index 1 sets the image pixel total. Write only while idle.
//   Throughput: one byte per cycle while in_stall is low.
//   Capture: a result is registered in the output register, or in the skid
//   register if that is held, when its last byte or the end marker is taken.
//   Reset: decoder returns to expecting a packet header, pixel count zero,
//   bytes per pixel 3, pixel total 1.
//   Stall: the output register plus one skid entry hold results; in_stall
//   rises only when both are full, and falls as soon as one drains.
module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic [1:0]  out_status,
  output logic        out_image_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0]  bpp_r;
  logic [31:0] total_r;
  logic [2:0]  bpp_eff;
  logic [31:0] total_eff;
  logic        in_accept;
  logic        buf_full;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RESET;
      total_r <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BYTES_PER_PIXEL) bpp_r <= cfg_data[2:0];
      if (cfg_index == CFG_PIXEL_TOTAL) total_r <= cfg_data;
    end
  end

  // Clamp pixel size into 1..MAX_PIXEL_BYTES and the total to at least one
  always_comb begin
    if (bpp_r == 3'd0) bpp_eff = 3'd1;
    else if (bpp_r > 3'(MAX_PIXEL_BYTES)) bpp_eff = 3'(MAX_PIXEL_BYTES);
    else bpp_eff = bpp_r;
  end

  assign total_eff = (total_r == 32'd0) ? 32'd1 : total_r;

  tgarle_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .bpp_eff    (bpp_eff),
    .total_eff  (total_eff),
    .res_valid  (res_valid),
    .res        (res)
  );

  tgarle_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_pixel_value  = out_data.pixel_value;
  assign out_repeat_count = out_data.repeat_count;
  assign out_status       = out_data.status;
  assign out_image_done   = out_data.image_done;

  a_bpp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bpp_eff != 3'd0) && (bpp_eff <= 3'(MAX_PIXEL_BYTES)))
    else $error("effective pixel size out of range");

  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_TRUNCATED) |-> out_image_done)
    else $error("truncation result without image_done");

  a_stall_follows_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("input still stalled after output drained");

endmodule

FILE: tb/tga_rle_checker.sv
// Checker for the TGA run-length decoder: follows register writes, predicts runs, compares results.
module tga_rle_checker
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_pixel_value,
  input  logic [7:0]  out_repeat_count,
  input  logic [1:0]  out_status,
  input  logic        out_image_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          bytes_seen,
  output int          runs_checked,
  output int          clipped_seen,
  output int          truncated_seen,
  output int          images_seen
);

  logic [2:0]  bpp_reg;
  logic [31:0] total_reg;

  logic [1:0]  phase;
  logic [1:0]  byte_index;
  logic [31:0] pixel_shift;
  logic [7:0]  packet_left;
  logic [31:0] pixels_done;

  result_t runs_q[$];

  task automatic clear_decoder();
    phase = PH_HEADER;
    byte_index = 2'd0;
    pixel_shift = 32'd0;
    packet_left = 8'd0;
    pixels_done = 32'd0;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    // keep the log short when the decoder is badly off
    if (fail_count < 100)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  // Advance the decoder by one stream byte or end marker; queue the run it yields.
  task automatic decode_byte(input logic [7:0] b, input logic stop);
    int unsigned bpp, total, want, remaining, give;
    result_t r;
    bpp = (bpp_reg == 3'd0) ? 1 : (bpp_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_reg;
    total = (total_reg == 32'd0) ? 1 : total_reg;
    if (stop) begin
      if (!(phase == PH_DISCARD || (phase == PH_HEADER && pixels_done == 32'd0))) begin
        r.pixel_value = 32'd0;
        r.repeat_count = 8'd0;
        r.status = ST_TRUNCATED;
        r.image_done = 1'b1;
        runs_q.push_back(r);
      end
      clear_decoder();
    end else if (phase == PH_HEADER) begin
      packet_left = {1'b0, b[6:0]} + 8'd1;
      phase = b[7] ? PH_REPEAT : PH_LITERAL;
      byte_index = 2'd0;
      pixel_shift = 32'd0;
    end else if (phase == PH_DISCARD) begin
      // drop one byte of a leftover literal pixel
      byte_index = byte_index + 2'd1;
      if (byte_index == 2'd0 || byte_index >= bpp) begin
        byte_index = 2'd0;
        if (packet_left != 8'd0) packet_left = packet_left - 8'd1;
        if (packet_left == 8'd0) phase = PH_HEADER;
      end
    end else begin
      pixel_shift = pixel_shift | (32'(b) << (8 * byte_index));
      if (int'(byte_index) + 1 < bpp) begin
        byte_index = byte_index + 2'd1;
      end else begin
        want = (phase == PH_REPEAT) ? packet_left : 1;
        remaining = (total > pixels_done) ? total - pixels_done : 0;
        give = (want < remaining) ? want : remaining;
        r.pixel_value = pixel_shift;
        r.repeat_count = give[7:0];
        r.status = (give < want) ? ST_CLIPPED : ST_NORMAL;
        r.image_done = 1'b0;
        pixel_shift = 32'd0;
        byte_index = 2'd0;
        if (phase == PH_REPEAT) packet_left = 8'd0;
        else if (packet_left != 8'd0) packet_left = packet_left - 8'd1;
        pixels_done = pixels_done + give;
        if (pixels_done >= total) begin
          r.image_done = 1'b1;
          pixels_done = 32'd0;
          if (phase == PH_LITERAL && packet_left != 8'd0) begin
            r.status = ST_CLIPPED;
            phase = PH_DISCARD;
          end else begin
            phase = PH_HEADER;
            packet_left = 8'd0;
          end
        end else if (packet_left == 8'd0) begin
          phase = PH_HEADER;
        end
        runs_q.push_back(r);
      end
    end
  endtask

  task automatic check_run();
    result_t want;
    if (runs_q.size() == 0) begin
      report("run with nothing expected", out_pixel_value, 32'd0);
    end else begin
      want = runs_q.pop_front();
      runs_checked++;
      if (want.status == ST_CLIPPED) clipped_seen++;
      if (want.status == ST_TRUNCATED) truncated_seen++;
      if (want.image_done) images_seen++;
      if (out_pixel_value !== want.pixel_value)
        report("pixel_value", out_pixel_value, want.pixel_value);
      if (out_repeat_count !== want.repeat_count)
        report("repeat_count", 32'(out_repeat_count), 32'(want.repeat_count));
      if (out_status !== want.status)
        report("status", 32'(out_status), 32'(want.status));
      if (out_image_done !== want.image_done)
        report("image_done", 32'(out_image_done), 32'(want.image_done));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bpp_reg = BPP_RESET;
      total_reg = TOTAL_RESET;
      clear_decoder();
      runs_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BYTES_PER_PIXEL) bpp_reg = cfg_data[2:0];
        else total_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        bytes_seen++;
        decode_byte(in_data_byte, in_stream_end);
      end
      if (out_valid && !out_stall) check_run();
    end
    pending <= runs_q.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the TGA run-length decoder regression: clock, reset, stimulus and verdict.
module tb;
  import tgarle_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_BYTES_PER_PIXEL;
  logic [31:0] cfg_data = 32'd0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_pixel_value;
  logic [7:0]  out_repeat_count;
  logic [1:0]  out_status;
  logic        out_image_done;
  logic        cfg_ready;

  int fail_count, pending, bytes_seen, runs_checked;
  int clipped_seen, truncated_seen, images_seen;

  logic       calm = 1'b0;     // no idling on either side while set
  logic [2:0] bpp_now = BPP_RESET;
  int         items_sent = 0;

  tga_rle_pixel_decoder dut (.*);
  tga_rle_checker chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tga_rle_pixel_decoder regression: fail");
    $finish;
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 28);

  task automatic send_item(input logic stop, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 28) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_end <= stop;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold input until every expected run is out, then let the last byte retire.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BYTES_PER_PIXEL) bpp_now = value[2:0];
    @(posedge clk);
  endtask

  task automatic send_packet(input logic run, input int unsigned len);
    int nb;
    nb = (bpp_now == 3'd0) ? 1 : (bpp_now > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_now;
    send_item(1'b0, {run, len[6:0]});
    repeat (run ? nb : (len + 1) * nb) send_item(1'b0, 8'($urandom));
  endtask

  initial begin
    int target, phase_no, packets, k;
    logic [2:0] bpp_pick;
    logic [31:0] total_pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one byte per pixel, four pixels per image
    write_cfg(CFG_BYTES_PER_PIXEL, 32'd1);
    write_cfg(CFG_PIXEL_TOTAL, 32'd4);
    send_item(1'b0, 8'h83);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);   // longest run, clipped to the image
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h82);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'h02);   // literal packet running past the image end
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h02);
    send_item(1'b0, 8'h03);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h80);
    send_item(1'b1, 8'hFF);   // truncated mid-image
    send_item(1'b1, 8'h00);   // end between images
    send_item(1'b0, 8'h05);
    repeat (4) send_item(1'b0, 8'($urandom));
    send_item(1'b0, 8'h7E);
    send_item(1'b1, 8'h00);   // end while dropping leftover bytes
    settle();

    // resize a pixel halfway, then pull the total below what is counted
    write_cfg(CFG_BYTES_PER_PIXEL, 32'd4);
    write_cfg(CFG_PIXEL_TOTAL, 32'd10);
    send_item(1'b0, 8'h81);
    send_item(1'b0, 8'h11);
    send_item(1'b0, 8'h22);
    settle();
    write_cfg(CFG_BYTES_PER_PIXEL, 32'd2);
    send_item(1'b0, 8'h33);
    send_item(1'b0, 8'h84);
    send_item(1'b0, 8'h44);
    settle();
    write_cfg(CFG_PIXEL_TOTAL, 32'd0);
    send_item(1'b0, 8'h55);

    target = items_sent + 400;
    phase_no = 0;
    while (items_sent < target) begin
      settle();
      k = $urandom_range(0, 9);
      bpp_pick = (k < 2) ? 3'($urandom_range(0, 7)) : (k < 5) ? 3'd1 :
                 (k < 7) ? 3'd3 : 3'($urandom_range(2, 4));
      k = $urandom_range(0, 9);
      total_pick = (k == 0) ? 32'hFFFE0001 : (k == 1) ? 32'hFFFFFFFF :
                   (k == 2) ? 32'd0 : 32'($urandom_range(1, 12));
      if ($urandom_range(0, 2) != 0)
        write_cfg(CFG_BYTES_PER_PIXEL, {29'($urandom), bpp_pick});
      if ($urandom_range(0, 2) != 0)
        write_cfg(CFG_PIXEL_TOTAL, total_pick);
      calm = (phase_no >= 6 && phase_no < 12);
      packets = $urandom_range(2, 8);
      repeat (packets) begin
        k = $urandom_range(0, 99);
        if (k < 4) send_item(1'b1, 8'($urandom));
        else if (k < 8) send_item(1'b0, 8'($urandom));
        else if ($urandom_range(0, 1) != 0)
          send_packet(1'b1, (k < 20) ? $urandom_range(0, 127) : $urandom_range(0, 4));
        else
          send_packet(1'b0, (k < 14 && bpp_now <= 3'd1) ?
                      $urandom_range(0, 127) : $urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) == 0) send_item(1'b1, 8'($urandom));
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Fed %0d stream bytes over %0d random phases; checked %0d runs.",
             bytes_seen, phase_no, runs_checked);
    $display("Of those, %0d clipped, %0d truncated, %0d closing an image.",
             clipped_seen, truncated_seen, images_seen);
    if (fail_count == 0) begin
      $display("tga_rle_pixel_decoder regression: pass");
    end else begin
      $display("tga_rle_pixel_decoder regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tgarle_pkg.sv
design/tgarle_step.sv
design/tgarle_skid.sv
design/tga_rle_pixel_decoder.sv
tb/tga_rle_checker.sv
tb/tb.sv
